FILE: hw/rtl/sle_pkg.sv
`default_nettype none
package sle_pkg;
  localparam int unsigned CapacityDefault = 32;
  localparam int unsigned ValueWidthDefault = 32;

  localparam logic [1:0] ModeAppend = 2'd0;
  localparam logic [1:0] ModeInsert = 2'd1;
  localparam logic [1:0] ModeDump   = 2'd2;
  localparam logic [1:0] ModeClear  = 2'd3;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CHECK,
    ST_SORT_SCAN,
    ST_SORT_SWAP_A,
    ST_SORT_SWAP_B,
    ST_FIND,
    ST_SHIFT,
    ST_DUMP,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/sle_ram.sv
`default_nettype none
module sle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sorted_list_engine.sv
// Sorted list engine: a bounded store of signed values kept in one RAM.
// Input channel in_valid/in_stall carries mode and value; one item is worked
// at a time and in_stall stays high until its last result is handed over.
// Result channel out_valid/out_stall carries entry, count, status, in_order
// and last. Every item gives one result except a dump of a non-empty list,
// which gives one beat per stored entry with last on the final beat.
// Work per item, on a RAM with one write port and one registered read port:
//   append, clear, refused write: a dispatch step, then the result.
//   insert into an ascending list: order check, search, shift.
//   insert into an unordered list: adds a selection sort of about n*n/2 reads.
//   dump: one RAM read per entry, then its beat.
// The in_order flag is held in a register, updated as entries are written.
// Reset clears the count and the control; RAM contents stay undefined and
// are never read beyond the count. A stalled result holds its payload and
// the engine waits for it.
`default_nettype none
module sorted_list_engine import sle_pkg::*; #(
  parameter int unsigned CAPACITY    = CapacityDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic signed [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_entry,
  output logic [6:0]       out_count,
  output logic [1:0]       out_status,
  output logic             out_in_order,
  output logic             out_last
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic ord_r, ord_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic signed [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, m_r, m_nxt;
  logic signed [VALUE_WIDTH-1:0] prev_r, prev_nxt, min_r, min_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic ov_r, ov_nxt;
  logic signed [31:0] oe_r, oe_nxt;
  logic [1:0] os_r, os_nxt;
  logic ol_r, ol_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [VALUE_WIDTH-1:0] wdata, rdata;

  sle_ram #(.Width(VALUE_WIDTH), .Depth(CAPACITY)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // hold off new beats until the pending result has left
  assign in_stall     = (state_r != ST_IDLE) || ov_r;
  assign out_valid    = ov_r;
  assign out_entry    = oe_r;
  assign out_count    = 7'(cnt_r);
  assign out_status   = os_r;
  assign out_in_order = ord_r;
  assign out_last     = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      ord_r <= 1'b1;
      ov_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ord_r <= ord_nxt;
      ov_r <= ov_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    mode_r <= mode_nxt; val_r <= val_nxt;
    i_r <= i_nxt; j_r <= j_nxt; m_r <= m_nxt;
    prev_r <= prev_nxt; min_r <= min_nxt;
    oe_r <= oe_nxt; os_r <= os_nxt; ol_r <= ol_nxt;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; ord_nxt = ord_r;
    mode_nxt = mode_r; val_nxt = val_r;
    i_nxt = i_r; j_nxt = j_r; m_nxt = m_r;
    prev_nxt = prev_r; min_nxt = min_r; rd_pend_nxt = 1'b0;
    ov_nxt = ov_r; oe_nxt = oe_r; os_nxt = os_r; ol_nxt = ol_r;
    we = 1'b0; waddr = '0; wdata = val_r; raddr = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          mode_nxt = in_mode;
          val_nxt = VALUE_WIDTH'(in_value);
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        oe_nxt = '0; os_nxt = StatusOk; ol_nxt = 1'b1;
        unique case (mode_r)
          ModeAppend: begin
            if (cnt_r >= CapC) begin
              os_nxt = StatusFull;
            end else begin
              we = 1'b1; waddr = AW'(cnt_r);
              if (cnt_r != '0 && val_r < prev_r) ord_nxt = 1'b0;
              prev_nxt = val_r;
              cnt_nxt = cnt_r + 1'b1;
            end
            state_nxt = ST_EMIT;
          end
          ModeInsert: begin
            if (cnt_r >= CapC) begin
              os_nxt = StatusFull;
              state_nxt = ST_EMIT;
            end else if (!ord_r) begin
              i_nxt = '0; j_nxt = '0; m_nxt = '0;
              state_nxt = ST_SORT_SCAN;
            end else begin
              i_nxt = '0;
              state_nxt = ST_FIND;
            end
          end
          ModeDump: begin
            if (cnt_r == '0) begin
              os_nxt = StatusEmpty;
              state_nxt = ST_EMIT;
            end else begin
              i_nxt = '0;
              state_nxt = ST_DUMP;
            end
          end
          default: begin
            cnt_nxt = '0; ord_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end
        endcase
      end
      // selection sort: i is the slot, j scans, m/min hold the minimum
      ST_SORT_SCAN: begin
        if (rd_pend_r) begin
          if (j_r == i_r || rdata < min_r) begin
            min_nxt = rdata; m_nxt = j_r;
          end
          if (j_r == i_r) prev_nxt = rdata;
          j_nxt = j_r + 1'b1;
        end
        if ((rd_pend_r ? j_r + 1'b1 : j_r) >= cnt_r && rd_pend_r) begin
          state_nxt = ST_SORT_SWAP_A;
        end else begin
          raddr = AW'(rd_pend_r ? j_r + 1'b1 : j_r);
          rd_pend_nxt = 1'b1;
        end
      end
      ST_SORT_SWAP_A: begin
        we = 1'b1; waddr = AW'(i_r); wdata = min_r;
        state_nxt = ST_SORT_SWAP_B;
      end
      ST_SORT_SWAP_B: begin
        we = 1'b1; waddr = AW'(m_r); wdata = prev_r;
        if (m_r == i_r) we = 1'b0;
        if (i_r + 2'd2 >= cnt_r) begin
          i_nxt = '0; ord_nxt = 1'b1;
          state_nxt = ST_FIND;
        end else begin
          i_nxt = i_r + 1'b1; j_nxt = i_r + 1'b1;
          state_nxt = ST_SORT_SCAN;
        end
      end
      // find first entry not smaller; i is the insert position
      ST_FIND: begin
        if (rd_pend_r && !(rdata < val_r)) begin
          j_nxt = cnt_r;
          state_nxt = ST_SHIFT;
        end else begin
          if (rd_pend_r) i_nxt = i_r + 1'b1;
          if ((rd_pend_r ? i_r + 1'b1 : i_r) >= cnt_r) begin
            j_nxt = cnt_r;
            state_nxt = ST_SHIFT;
          end else begin
            raddr = AW'(rd_pend_r ? i_r + 1'b1 : i_r);
            rd_pend_nxt = 1'b1;
          end
        end
      end
      // shift tail up one slot: read j-1, write it at j
      ST_SHIFT: begin
        if (rd_pend_r) begin
          we = 1'b1; waddr = AW'(j_r); wdata = rdata;
          // the old tail stays the tail after the shift
          if (j_r == cnt_r) prev_nxt = rdata;
          j_nxt = j_r - 1'b1;
        end else if (j_r > i_r) begin
          raddr = AW'(j_r - 1'b1);
          rd_pend_nxt = 1'b1;
        end else begin
          we = 1'b1; waddr = AW'(i_r); wdata = val_r;
          if (i_r == cnt_r) prev_nxt = val_r;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_DUMP: begin
        if (rd_pend_r) begin
          if (!ov_r || !out_stall) begin
            ov_nxt = 1'b1;
            oe_nxt = 32'($unsigned(rdata));
            os_nxt = StatusOk;
            ol_nxt = (i_r + 1'b1 == cnt_r);
            if (i_r + 1'b1 == cnt_r) begin
              state_nxt = ST_IDLE;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end else begin
            raddr = AW'(i_r);
            rd_pend_nxt = 1'b1;
          end
        end else begin
          raddr = AW'(i_r);
          rd_pend_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  localparam int unsigned Cap = CapacityDefault;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic signed [31:0] entry;
    logic [6:0]         count;
    logic [1:0]         status;
    logic               in_order;
    logic               last;
  } list_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = ModeAppend;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_entry;
  logic [6:0] out_count;
  logic [1:0] out_status;
  logic out_in_order;
  logic out_last;

  sorted_list_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_entry(out_entry), .out_count(out_count), .out_status(out_status),
    .out_in_order(out_in_order), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted store contents
  logic signed [31:0] shadow_list [Cap];
  int unsigned shadow_count = 0;
  list_beat_t expected_beats [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit hold_off = 1'b0;
  int unsigned burst_left = 0;

  function automatic bit list_ascending();
    for (int unsigned i = 1; i < shadow_count; i++)
      if (shadow_list[i] < shadow_list[i-1]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic list_beat_t make_beat(logic signed [31:0] ent, logic [1:0] st,
                                           bit lst);
    list_beat_t b;
    b.entry = ent;
    b.count = shadow_count[6:0];
    b.status = st;
    b.in_order = list_ascending();
    b.last = lst;
    return b;
  endfunction

  task automatic predict_list_op(logic [1:0] mode, logic signed [31:0] value);
    int unsigned pos, m;
    logic signed [31:0] t;
    case (mode)
      ModeAppend, ModeInsert: begin
        if (shadow_count >= Cap) begin
          expected_beats.push_back(make_beat('0, StatusFull, 1'b1));
        end else if (mode == ModeAppend) begin
          shadow_list[shadow_count] = value;
          shadow_count++;
          expected_beats.push_back(make_beat('0, StatusOk, 1'b1));
        end else begin
          if (!list_ascending()) begin
            for (int unsigned i = 0; i + 1 < shadow_count; i++) begin
              m = i;
              for (int unsigned j = i + 1; j < shadow_count; j++)
                if (shadow_list[j] < shadow_list[m]) m = j;
              t = shadow_list[i];
              shadow_list[i] = shadow_list[m];
              shadow_list[m] = t;
            end
          end
          pos = 0;
          while (pos < shadow_count && shadow_list[pos] < value) pos++;
          for (int unsigned i = shadow_count; i > pos; i--)
            shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = value;
          shadow_count++;
          expected_beats.push_back(make_beat('0, StatusOk, 1'b1));
        end
      end
      ModeDump: begin
        if (shadow_count == 0)
          expected_beats.push_back(make_beat('0, StatusEmpty, 1'b1));
        for (int unsigned i = 0; i < shadow_count; i++)
          expected_beats.push_back(make_beat(shadow_list[i], StatusOk,
                                             i + 1 == shadow_count));
      end
      default: begin
        shadow_count = 0;
        expected_beats.push_back(make_beat('0, StatusOk, 1'b1));
      end
    endcase
  endtask

  // send one item, with a random gap between bursts
  task automatic send_op(logic [1:0] mode, logic signed [31:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_value <= value;
    // in_stall only moves at rising edges; sample it mid-cycle
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_list_op(mode, value);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat entry", out_entry, 0);
      end else begin
        list_beat_t w;
        w = expected_beats.pop_front();
        if (out_entry !== w.entry) report_mismatch("entry", out_entry, w.entry);
        if (out_count !== w.count) report_mismatch("count", out_count, w.count);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_in_order !== w.in_order)
          report_mismatch("in_order", out_in_order, w.in_order);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  // receiver stall pattern, with calm stretches and forced hold-offs
  always @(posedge clk) begin
    int unsigned ph;
    ph = $urandom_range(99);
    if (hold_off) out_stall <= 1'b1;
    else if (ph < 40) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(3) == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic drain();
    stop_sending();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(8))) - 4;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_op(ModeDump, 0);
    send_op(ModeAppend, 32'sh7FFFFFFF);
    send_op(ModeAppend, 32'sh80000000);
    send_op(ModeAppend, -1);
    send_op(ModeAppend, 0);
    send_op(ModeDump, 32'shFFFFFFFF);
    send_op(ModeInsert, 5);
    send_op(ModeInsert, 5);
    send_op(ModeInsert, 32'sh80000000);
    send_op(ModeInsert, 32'sh7FFFFFFF);
    send_op(ModeDump, 0);
    send_op(ModeClear, 32'sh55555555);
    send_op(ModeInsert, 32'shAAAAAAAA);
    send_op(ModeDump, 0);
    send_op(ModeClear, 0);
    send_op(ModeDump, 0);
    drain();
  endtask

  task automatic test_full_store();
    for (int unsigned i = 0; i < Cap; i++) send_op(ModeAppend, rand_value());
    send_op(ModeAppend, 1);
    send_op(ModeInsert, 2);
    send_op(ModeDump, 0);
    send_op(ModeClear, 0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int unsigned i = 0; i < 12; i++) send_op(ModeAppend, rand_value());
    join
    send_op(ModeDump, 0);
    send_op(ModeClear, 0);
    drain();
  endtask

  task automatic test_random_ops();
    int unsigned p;
    for (int unsigned i = 0; i < 115; i++) begin
      p = $urandom_range(99);
      if (p < 40) send_op(ModeAppend, rand_value());
      else if (p < 80) send_op(ModeInsert, rand_value());
      else if (p < 93) send_op(ModeDump, $urandom);
      else send_op(ModeClear, $urandom);
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_backpressure();
    test_random_ops();
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_ram.sv
hw/rtl/sorted_list_engine.sv
tb/testbench.sv
